@@ rtl/binary_to_decimal_ascii_macros.svh @@
// Assertion macros shared by the binary to decimal ASCII converter modules.
`ifndef BINARY_TO_DECIMAL_ASCII_MACROS_SVH
`define BINARY_TO_DECIMAL_ASCII_MACROS_SVH

`ifndef ASSERT_OFF

// Check a condition at every clock edge outside reset.
`define B2DA_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a trigger is followed by a condition in the next clock cycle.
`define B2DA_ASSERT_NEXT(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`else

`define B2DA_ASSERT_ALWAYS(lbl, cond, msg)
`define B2DA_ASSERT_NEXT(lbl, trig, cond, msg)

`endif

`endif

@@ rtl/b2da_pkg.sv @@
// Shared types and constants for the binary to decimal ASCII converter.
`timescale 1ns / 1ps

package b2da_pkg;

    localparam int VALUE_W    = 64;
    localparam int BCD_DIGITS = 20;
    localparam int BCD_W      = 4 * BCD_DIGITS;
    localparam int BIT_CNT_W  = $clog2(VALUE_W);
    localparam int REMAIN_W   = $clog2(BCD_DIGITS + 1);
    localparam int CHAR_W     = 6;
    localparam int TDATA_W    = 8;

    localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

    typedef enum logic [1:0] {
        CONV_IDLE,
        CONV_SHIFT,
        CONV_DONE
    } conv_state_t;

    typedef enum logic [1:0] {
        EMIT_IDLE,
        EMIT_SKIP,
        EMIT_SEND
    } emit_state_t;

    // Finished BCD word offered by the converter to the emitter.
    typedef struct packed {
        logic             valid;
        logic [BCD_W-1:0] bcd;
    } bcd_xfer_t;

    // Add 3 to every BCD digit that is 5 or more, ahead of the next shift.
    function automatic logic [BCD_W-1:0] bcd_adjust(input logic [BCD_W-1:0] bcd);
        logic [BCD_W-1:0] res;
        logic [3:0]       dig;
        res = bcd;
        for (int i = 0; i < BCD_DIGITS; i++)
        begin
            dig = bcd[4*i +: 4];
            if (dig >= 4'd5)
            begin
                res[4*i +: 4] = dig + 4'd3;
            end
        end
        return res;
    endfunction

endpackage

@@ rtl/binary_to_decimal_ascii.sv @@
// Top level of the binary to decimal ASCII converter.
`timescale 1ns / 1ps

// Converts an unsigned 64-bit number into its decimal digits as ASCII characters,
// most significant first, without leading zeros; zero gives the single character
// '0', and tlast marks the final digit. A request is taken only while the
// shift-and-add-3 converter is free; it loads the value when taken and then shifts
// in one input bit per cycle. The finished BCD word moves to the emitter, which
// drops up to 19 leading zeros, one per cycle, then settles on the first digit
// and sends one digit per cycle while m_tready is high; without stalls its time
// per number does not depend on the digit count. The next request converts while
// the previous number's digits are still going out, so a steady stream of numbers
// is paced by the conversion, slower only when output stalls keep the emitter
// busy past it.
module binary_to_decimal_ascii (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [b2da_pkg::VALUE_W-1:0]      s_tdata,   // [63:0] value
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [b2da_pkg::TDATA_W-1:0]      m_tdata,   // [5:0] digit_char, [7:6] zero
    output logic                              m_tlast    // last_digit
);

    b2da_pkg::bcd_xfer_t                 xfer;
    logic                                xfer_ready;
    logic [b2da_pkg::CHAR_W-1:0]         digit_char;

    b2da_dabble u_dabble (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_value   (s_tdata),
        .xfer       (xfer),
        .xfer_ready (xfer_ready)
    );

    b2da_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .xfer       (xfer),
        .xfer_ready (xfer_ready),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_char   (digit_char),
        .out_last   (m_tlast)
    );

    assign m_tdata = {{(b2da_pkg::TDATA_W - b2da_pkg::CHAR_W){1'b0}}, digit_char};

endmodule

@@ rtl/b2da_dabble.sv @@
// Shift-and-add-3 converter: one input bit per cycle into a packed BCD word.
`timescale 1ns / 1ps
`include "binary_to_decimal_ascii_macros.svh"

module b2da_dabble (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [b2da_pkg::VALUE_W-1:0]  in_value,
    output b2da_pkg::bcd_xfer_t           xfer,
    input  logic                          xfer_ready
);

    b2da_pkg::conv_state_t               state_reg, state_next;
    logic [b2da_pkg::VALUE_W-1:0]        bin_reg, bin_next;
    logic [b2da_pkg::BCD_W-1:0]          bcd_reg, bcd_next;
    logic [b2da_pkg::BIT_CNT_W-1:0]      bit_cnt_reg, bit_cnt_next;
    logic [b2da_pkg::BCD_W-1:0]          bcd_adj;
    logic                                last_bit;

    assign bcd_adj  = b2da_pkg::bcd_adjust(bcd_reg);
    assign last_bit = (bit_cnt_reg == b2da_pkg::BIT_CNT_W'(b2da_pkg::VALUE_W - 1));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            b2da_pkg::CONV_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = b2da_pkg::CONV_SHIFT;
                end
            end
            b2da_pkg::CONV_SHIFT:
            begin
                if (last_bit)
                begin
                    state_next = b2da_pkg::CONV_DONE;
                end
            end
            b2da_pkg::CONV_DONE:
            begin
                if (xfer_ready)
                begin
                    state_next = b2da_pkg::CONV_IDLE;
                end
            end
            default:
            begin
                state_next = b2da_pkg::CONV_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready   = (state_reg == b2da_pkg::CONV_IDLE);
        xfer.valid = (state_reg == b2da_pkg::CONV_DONE);
        xfer.bcd   = bcd_reg;
    end

    always_comb
    begin
        bin_next     = bin_reg;
        bcd_next     = bcd_reg;
        bit_cnt_next = bit_cnt_reg;
        case (state_reg)
            b2da_pkg::CONV_IDLE:
            begin
                bin_next     = in_value;
                bcd_next     = '0;
                bit_cnt_next = '0;
            end
            b2da_pkg::CONV_SHIFT:
            begin
                // Adjust, then shift the next binary bit into the BCD word.
                bcd_next     = {bcd_adj[b2da_pkg::BCD_W-2:0],
                                bin_reg[b2da_pkg::VALUE_W-1]};
                bin_next     = {bin_reg[b2da_pkg::VALUE_W-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg + b2da_pkg::BIT_CNT_W'(1);
            end
            default:
            begin
                bin_next = bin_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= b2da_pkg::CONV_IDLE;
            bit_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            bit_cnt_reg <= bit_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    `B2DA_ASSERT_NEXT(a_conv_done,
        (state_reg == b2da_pkg::CONV_SHIFT) && last_bit,
        xfer.valid,
        "conversion did not finish after the last bit")
    `B2DA_ASSERT_NEXT(a_conv_start,
        in_valid && in_ready,
        (state_reg == b2da_pkg::CONV_SHIFT) && (bit_cnt_reg == '0),
        "accepted request did not start a conversion")

endmodule

@@ rtl/b2da_emit.sv @@
// Digit emitter: drops leading zeros and sends the remaining digits as ASCII characters.
`timescale 1ns / 1ps
`include "binary_to_decimal_ascii_macros.svh"

module b2da_emit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  b2da_pkg::bcd_xfer_t           xfer,
    output logic                          xfer_ready,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [b2da_pkg::CHAR_W-1:0]   out_char,
    output logic                          out_last
);

    b2da_pkg::emit_state_t               state_reg, state_next;
    logic [b2da_pkg::BCD_W-1:0]          dig_reg, dig_next;
    logic [b2da_pkg::REMAIN_W-1:0]       remain_reg, remain_next;
    logic [3:0]                          top_dig;
    logic                                one_left;
    logic                                skip_zero;

    assign top_dig   = dig_reg[b2da_pkg::BCD_W-1 -: 4];
    assign one_left  = (remain_reg == b2da_pkg::REMAIN_W'(1));
    assign skip_zero = (top_dig == 4'd0) && !one_left;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            b2da_pkg::EMIT_IDLE:
            begin
                if (xfer.valid)
                begin
                    state_next = b2da_pkg::EMIT_SKIP;
                end
            end
            b2da_pkg::EMIT_SKIP:
            begin
                if (!skip_zero)
                begin
                    state_next = b2da_pkg::EMIT_SEND;
                end
            end
            b2da_pkg::EMIT_SEND:
            begin
                if (out_ready && one_left)
                begin
                    state_next = b2da_pkg::EMIT_IDLE;
                end
            end
            default:
            begin
                state_next = b2da_pkg::EMIT_IDLE;
            end
        endcase
    end

    always_comb
    begin
        xfer_ready = (state_reg == b2da_pkg::EMIT_IDLE);
        out_valid  = (state_reg == b2da_pkg::EMIT_SEND);
        out_char   = b2da_pkg::ASCII_ZERO + b2da_pkg::CHAR_W'(top_dig);
        out_last   = one_left;
    end

    always_comb
    begin
        dig_next    = dig_reg;
        remain_next = remain_reg;
        case (state_reg)
            b2da_pkg::EMIT_IDLE:
            begin
                dig_next    = xfer.bcd;
                remain_next = b2da_pkg::REMAIN_W'(b2da_pkg::BCD_DIGITS);
            end
            b2da_pkg::EMIT_SKIP:
            begin
                if (skip_zero)
                begin
                    dig_next    = {dig_reg[b2da_pkg::BCD_W-5:0], 4'd0};
                    remain_next = remain_reg - b2da_pkg::REMAIN_W'(1);
                end
            end
            b2da_pkg::EMIT_SEND:
            begin
                // Advance to the next digit once this one is taken.
                if (out_ready)
                begin
                    dig_next    = {dig_reg[b2da_pkg::BCD_W-5:0], 4'd0};
                    remain_next = remain_reg - b2da_pkg::REMAIN_W'(1);
                end
            end
            default:
            begin
                dig_next = dig_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= b2da_pkg::EMIT_IDLE;
            remain_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            remain_reg <= remain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dig_reg <= dig_next;
    end

    `B2DA_ASSERT_ALWAYS(a_digit_range,
        !out_valid || (top_dig <= 4'd9),
        "emitted digit is not decimal")
    `B2DA_ASSERT_ALWAYS(a_remain_nonzero,
        (state_reg == b2da_pkg::EMIT_IDLE) || (remain_reg != '0),
        "digit count ran out while busy")
    `B2DA_ASSERT_ALWAYS(a_no_lead_zero,
        !((state_reg == b2da_pkg::EMIT_SKIP) && (state_next == b2da_pkg::EMIT_SEND))
            || (top_dig != 4'd0) || one_left,
        "leading zero would be emitted")
    `B2DA_ASSERT_NEXT(a_gap_after_last,
        out_valid && out_ready && out_last,
        !out_valid,
        "digit sent after the last one")

endmodule
